// ----- rtl/core/mfd_pkg.sv -----
// Shared types and constants for the meter frame decoder.
// Depends on nothing; imported by every module of the decoder.
`default_nettype none

package mfd_pkg;

  // Framing bytes.
  localparam logic [7:0] SOF_BYTE = 8'h02;
  localparam logic [7:0] EOF_BYTE = 8'h0D;

  // The decoded fields span the first fourteen characters of a frame.
  localparam int unsigned FIELD_SPAN = 14;

  // Character classes used by the field conversion.
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;

  // Unit codes on the wire and as reported.
  localparam logic [13:0] TUNIT_CODE_C  = 14'd1;
  localparam logic [13:0] TUNIT_CODE_F  = 14'd2;
  localparam logic [13:0] OUNIT_CODE_PC = 14'd6;
  localparam logic [13:0] OUNIT_CODE_MG = 14'd7;
  localparam logic [1:0]  UNIT_UNKNOWN  = 2'd0;
  localparam logic [1:0]  UNIT_FIRST    = 2'd1;
  localparam logic [1:0]  UNIT_SECOND   = 2'd2;

  // Polarity digits.
  localparam logic [3:0] POL_POS_A = 4'd0;
  localparam logic [3:0] POL_POS_B = 4'd1;
  localparam logic [3:0] POL_NEG_A = 4'd2;
  localparam logic [3:0] POL_NEG_B = 4'd3;

  // Snapshot of the open frame as seen by the field decoder.
  typedef struct packed {
    logic [FIELD_SPAN-1:0][7:0] chars;
    logic [FIELD_SPAN-1:0]      vld;    // position holds a received character
    logic                       short_frame;
  } frame_view_t;

  // Decoded fields of one closed frame.
  typedef struct packed {
    logic [3:0]  pol;
    logic [1:0]  tunit;
    logic [1:0]  ounit;
    logic [3:0]  ldp;
    logic [3:0]  udp;
    logic [13:0] lread;
    logic [13:0] uread;
  } frame_fields_t;

endpackage

`default_nettype wire

// ----- rtl/core/mfd_frame_buf.sv -----
// Frame state: open flag, character count and the stored leading characters.
// Depends on mfd_pkg.
`default_nettype none

module mfd_frame_buf
  import mfd_pkg::*;
#(
  parameter int unsigned FRAME_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,      // process rx_byte this cycle
  input  wire logic [7:0]  rx_byte,
  output logic             closes,    // rx_byte would close an open frame
  output frame_view_t      view
);

  localparam int unsigned CW = $clog2(FRAME_DEPTH + 1);

  logic          in_frame_r, in_frame_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [FIELD_SPAN-1:0][7:0] chars_r;
  logic [FIELD_SPAN-1:0]      vld;
  logic          store;

  assign store  = (rx_byte != SOF_BYTE) && (rx_byte != EOF_BYTE) && in_frame_r &&
                  (count_r < CW'(FRAME_DEPTH));
  assign closes = (rx_byte == EOF_BYTE) && in_frame_r;

  always_comb begin
    in_frame_nxt = in_frame_r;
    count_nxt    = count_r;
    if (rx_byte == SOF_BYTE) begin
      in_frame_nxt = 1'b1;
      count_nxt    = '0;
    end else if (rx_byte == EOF_BYTE) begin
      in_frame_nxt = 1'b0;
    end else if (store) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      count_r    <= '0;
    end else if (step) begin
      in_frame_r <= in_frame_nxt;
      count_r    <= count_nxt;
    end
  end

  // Only the leading characters are ever decoded; later ones are just counted.
  always_ff @(posedge clk) begin
    if (step && store) begin
      for (int g = 0; g < FIELD_SPAN; g++) begin
        if (count_r == CW'(g)) begin
          chars_r[g] <= rx_byte;
        end
      end
    end
  end

  always_comb begin
    for (int g = 0; g < FIELD_SPAN; g++) begin
      vld[g] = count_r > CW'(g);
    end
  end

  assign view.chars       = chars_r;
  assign view.vld         = vld;
  assign view.short_frame = count_r < CW'(FIELD_SPAN);

endmodule

`default_nettype wire

// ----- rtl/core/mfd_field_dec.sv -----
// Fixed-offset ASCII field conversion of a frame snapshot.
// Depends on mfd_pkg.
`default_nettype none

module mfd_field_dec
  import mfd_pkg::*;
(
  input  frame_view_t   view,
  output frame_fields_t fields
);

  // Leading-space skip, then a decimal digit run; unreceived positions end it.
  function automatic logic [13:0] field_conv(input frame_view_t fr,
                                             input int unsigned off,
                                             input int unsigned len);
    logic        skipping;
    logic        done;
    logic [7:0]  ch;
    logic [16:0] acc;
    skipping = 1'b1;
    done     = 1'b0;
    acc      = '0;
    ch       = '0;
    for (int unsigned k = 0; k < 4; k++) begin
      if (k < len && !done) begin
        ch = fr.chars[off + k];
        if (!fr.vld[off + k]) begin
          done = 1'b1;
        end else if (skipping && (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR))) begin
          skipping = 1'b1;
        end else begin
          skipping = 1'b0;
          if (ch >= CH_ZERO && ch <= CH_NINE) begin
            acc = 17'(acc * 17'd10) + 17'(ch - CH_ZERO);
          end else begin
            done = 1'b1;
          end
        end
      end
    end
    return acc[13:0];
  endfunction

  logic [13:0] pol_v, tunit_v, ounit_v, ldp_v, udp_v;

  assign pol_v   = field_conv(view, 0, 1);
  assign tunit_v = field_conv(view, 1, 1);
  assign ounit_v = field_conv(view, 2, 2);
  assign ldp_v   = field_conv(view, 4, 1);
  assign udp_v   = field_conv(view, 5, 1);

  assign fields.lread = field_conv(view, 6, 4);
  assign fields.uread = field_conv(view, 10, 4);
  assign fields.pol   = pol_v[3:0];
  assign fields.ldp   = ldp_v[3:0];
  assign fields.udp   = udp_v[3:0];

  assign fields.tunit = (tunit_v == TUNIT_CODE_C) ? UNIT_FIRST :
                        (tunit_v == TUNIT_CODE_F) ? UNIT_SECOND : UNIT_UNKNOWN;
  assign fields.ounit = (ounit_v == OUNIT_CODE_PC) ? UNIT_FIRST :
                        (ounit_v == OUNIT_CODE_MG) ? UNIT_SECOND : UNIT_UNKNOWN;

endmodule

`default_nettype wire

// ----- rtl/core/meter_frame_decoder.sv -----
// Top level of the dissolved-oxygen meter frame decoder.
// Depends on mfd_pkg, mfd_frame_buf and mfd_field_dec.
`default_nettype none

// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+------------------------------------
// in_      | input     | in_valid / in_ready  | in_rx_byte
// out_     | output    | out_valid / out_ready| temperature, units, oxygen, digits,
//          |           |                      | short_frame
//
// Each received byte is registered on transfer and then processed from that register;
// a closing CR, once processed, loads its result into the output register and raises
// out_valid. One byte is taken per cycle when the output side keeps up; the single
// output register is the only stall point, and only a closing CR waits on it.
// Synchronous active-low reset closes any open frame, clears the count and zeroes
// the held temperature.

module meter_frame_decoder
  import mfd_pkg::*;
#(
  parameter int unsigned FRAME_DEPTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   in_rx_byte,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic signed [14:0] out_temperature_tenths,
  output logic [1:0]        out_temperature_unit,
  output logic [13:0]       out_oxygen_tenths,
  output logic [1:0]        out_oxygen_unit,
  output logic [3:0]        out_polarity_code,
  output logic [3:0]        out_lower_decimals,
  output logic [3:0]        out_upper_decimals,
  output logic              out_short_frame
);

  // Input register.
  logic       in_vld_r;
  logic [7:0] in_byte_r;

  // Processing control.
  logic          closes;
  logic          out_free;
  logic          proc_fire;
  logic          emit;
  frame_view_t   view;
  frame_fields_t fields;

  logic signed [14:0] held_temp_r, held_temp_nxt;
  logic               out_vld_r;

  assign out_free  = !out_vld_r || out_ready;
  // A closing CR needs the output register; any other byte never waits.
  assign proc_fire = in_vld_r && (!closes || out_free);
  assign emit      = proc_fire && closes;
  assign in_ready  = !in_vld_r || proc_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  mfd_frame_buf #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (proc_fire),
    .rx_byte (in_byte_r),
    .closes  (closes),
    .view    (view)
  );

  mfd_field_dec u_dec (
    .view   (view),
    .fields (fields)
  );

  // Positive polarity takes the reading, negative negates it, anything else holds.
  always_comb begin
    held_temp_nxt = held_temp_r;
    if (fields.pol == POL_POS_A || fields.pol == POL_POS_B) begin
      held_temp_nxt = $signed({1'b0, fields.lread});
    end else if (fields.pol == POL_NEG_A || fields.pol == POL_NEG_B) begin
      held_temp_nxt = -$signed({1'b0, fields.lread});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_temp_r <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      if (emit) begin
        held_temp_r <= held_temp_nxt;
        out_vld_r   <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_temperature_tenths <= held_temp_nxt;
      out_temperature_unit   <= fields.tunit;
      out_oxygen_tenths      <= fields.uread;
      out_oxygen_unit        <= fields.ounit;
      out_polarity_code      <= fields.pol;
      out_lower_decimals     <= fields.ldp;
      out_upper_decimals     <= fields.udp;
      out_short_frame        <= view.short_frame;
    end
  end

  assign out_valid = out_vld_r;

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking testbench for meter_frame_decoder: serial bytes in, decoded readings out.
// Depends on mfd_pkg and the decoder RTL; it predicts every reading itself and checks
// each output transfer against it.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mfd_pkg::*;

  localparam int unsigned FRAME_DEPTH  = 32;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PHASE_BYTES  = 360;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned REPORT_LIMIT = 10;

  // One decoded reading, laid out like the output ports.
  typedef struct packed {
    logic signed [14:0] temp_tenths;
    logic [1:0]         temp_unit;
    logic [13:0]        oxy_tenths;
    logic [1:0]         oxy_unit;
    logic [3:0]         polarity;
    logic [3:0]         lower_dp;
    logic [3:0]         upper_dp;
    logic               short_f;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [14:0] out_temperature_tenths;
  logic [1:0]         out_temperature_unit;
  logic [13:0]        out_oxygen_tenths;
  logic [1:0]         out_oxygen_unit;
  logic [3:0]         out_polarity_code;
  logic [3:0]         out_lower_decimals;
  logic [3:0]         out_upper_decimals;
  logic               out_short_frame;

  meter_frame_decoder #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_rx_byte            (in_rx_byte),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_temperature_tenths(out_temperature_tenths),
    .out_temperature_unit  (out_temperature_unit),
    .out_oxygen_tenths     (out_oxygen_tenths),
    .out_oxygen_unit       (out_oxygen_unit),
    .out_polarity_code     (out_polarity_code),
    .out_lower_decimals    (out_lower_decimals),
    .out_upper_decimals    (out_upper_decimals),
    .out_short_frame       (out_short_frame)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bytes waiting to be offered on the input channel; the head is the one on the
  // port while in_valid is high, and it is removed only when its transfer happens.
  logic [7:0] pending_bytes[$];
  // Readings the decoder owes us, oldest first.
  reading_t   readings_due[$];

  // Idle and stall rates in percent, changed by the stimulus process per phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Long receiver hold-off, requested by a one-cycle pulse and counted down here.
  logic        hold_req = 1'b0;
  int unsigned hold_left = 0;

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_queued = 0;

  // Our own copy of the decoder's state.
  logic        frame_open = 1'b0;
  int unsigned stored_len = 0;
  logic [7:0]  frame_buf[FRAME_DEPTH];
  int          held_tenths = 0;

  // Space and the control characters from tab through CR are skipped before digits.
  function automatic logic is_blank(input logic [7:0] ch);
    return ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR);
  endfunction

  // Converts the field at [off, off+len): leading blanks, then a digit run, no sign.
  // Positions not received in this frame end the field as if they were non-digits.
  function automatic int unsigned field_number(input int unsigned off,
                                               input int unsigned len);
    int unsigned i;
    int unsigned v;
    logic [7:0]  ch;
    i = 0;
    v = 0;
    while (i < len && off + i < stored_len && off + i < FRAME_DEPTH &&
           is_blank(frame_buf[off + i]))
      i++;
    while (i < len && off + i < stored_len && off + i < FRAME_DEPTH) begin
      ch = frame_buf[off + i];
      if (ch < CH_ZERO || ch > CH_NINE)
        break;
      v = v * 10 + (ch - CH_ZERO);
      i++;
    end
    return v;
  endfunction

  // Applies one accepted byte to the predicted state and queues the reading that a
  // closing CR produces.
  task automatic absorb_byte(input logic [7:0] b);
    int unsigned pol, tu, ou, ldp, udp, lower_rd, upper_rd;
    reading_t    r;
    if (b == SOF_BYTE) begin
      frame_open = 1'b1;
      stored_len = 0;
    end else if (b != EOF_BYTE) begin
      if (frame_open && stored_len < FRAME_DEPTH) begin
        frame_buf[stored_len] = b;
        stored_len++;
      end
    end else if (frame_open) begin
      frame_open = 1'b0;
      pol      = field_number(0, 1);
      tu       = field_number(1, 1);
      ou       = field_number(2, 2);
      ldp      = field_number(4, 1);
      udp      = field_number(5, 1);
      lower_rd = field_number(6, 4);
      upper_rd = field_number(10, 4);
      // Polarity outside 0..3 leaves the previous temperature in place.
      if (pol == POL_POS_A || pol == POL_POS_B)
        held_tenths = int'(lower_rd);
      else if (pol == POL_NEG_A || pol == POL_NEG_B)
        held_tenths = -int'(lower_rd);
      r.temp_tenths = 15'(held_tenths);
      r.temp_unit   = (tu == TUNIT_CODE_C) ? UNIT_FIRST :
                      (tu == TUNIT_CODE_F) ? UNIT_SECOND : UNIT_UNKNOWN;
      r.oxy_tenths  = 14'(upper_rd);
      r.oxy_unit    = (ou == OUNIT_CODE_PC) ? UNIT_FIRST :
                      (ou == OUNIT_CODE_MG) ? UNIT_SECOND : UNIT_UNKNOWN;
      r.polarity    = 4'(pol);
      r.lower_dp    = 4'(ldp);
      r.upper_dp    = 4'(udp);
      r.short_f     = stored_len < FIELD_SPAN;
      readings_due.push_back(r);
    end
  endtask

  // Input driver. At each edge it first retires a byte whose transfer just happened,
  // then decides whether to present the next one. Valid is only dropped when no byte
  // is on the port, so an offered byte stays put until it is taken.
  always @(posedge clk) begin : driver
    logic took;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && in_ready;
      if (took) begin
        absorb_byte(in_rx_byte);
        void'(pending_bytes.pop_front());
      end
      if (took || !in_valid) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid   <= 1'b1;
          in_rx_byte <= pending_bytes[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : hold_counter
    if (hold_req)
      hold_left <= HOLD_CYCLES;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  // Output monitor. Every result transfer is matched against the oldest reading due;
  // out_ready is redrawn each cycle and kept low during a requested hold-off.
  always @(posedge clk) begin : monitor
    reading_t got;
    reading_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.temp_tenths = out_temperature_tenths;
        got.temp_unit   = out_temperature_unit;
        got.oxy_tenths  = out_oxygen_tenths;
        got.oxy_unit    = out_oxygen_unit;
        got.polarity    = out_polarity_code;
        got.lower_dp    = out_lower_decimals;
        got.upper_dp    = out_upper_decimals;
        got.short_f     = out_short_frame;
        if (readings_due.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("[%0t] unexpected reading: temp %0d oxy %0d pol %0d", $realtime,
                     got.temp_tenths, got.oxy_tenths, got.polarity);
        end else begin
          want = readings_due.pop_front();
          if (got.temp_tenths !== want.temp_tenths || got.temp_unit !== want.temp_unit ||
              got.oxy_tenths !== want.oxy_tenths || got.oxy_unit !== want.oxy_unit ||
              got.polarity !== want.polarity || got.lower_dp !== want.lower_dp ||
              got.upper_dp !== want.upper_dp || got.short_f !== want.short_f) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("[%0t] reading mismatch (exp/got): temp %0d/%0d tunit %0d/%0d",
                       $realtime, want.temp_tenths, got.temp_tenths,
                       want.temp_unit, got.temp_unit);
              $display("  oxy %0d/%0d ounit %0d/%0d pol %0d/%0d",
                       want.oxy_tenths, got.oxy_tenths, want.oxy_unit, got.oxy_unit,
                       want.polarity, got.polarity);
              $display("  ldp %0d/%0d udp %0d/%0d short %0d/%0d",
                       want.lower_dp, got.lower_dp, want.upper_dp, got.upper_dp,
                       want.short_f, got.short_f);
            end
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Bytes that go into frames count toward the run length; pure noise does not.
  task automatic offer(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic offer_text(input string s);
    for (int i = 0; i < s.len(); i++)
      offer(s[i]);
  endtask

  // Picks one frame character. Mostly digits, biased toward the valid polarity and
  // unit codes at their offsets, with blanks, signs, NUL, tabs and arbitrary bytes
  // mixed in. Framing bytes are kept out so the frame shape stays as chosen.
  function automatic logic [7:0] pick_char(input int unsigned pos);
    int unsigned r;
    int unsigned d;
    logic [7:0]  c;
    r = $urandom_range(0, 99);
    if (r < 12) return CH_SPACE;
    if (r < 16) return r[0] ? "+" : "-";
    if (r < 18) return 8'h00;
    if (r < 20) return 8'($urandom_range(CH_TAB, CH_CR - 1));
    if (r < 25) begin
      c = 8'($urandom_range(0, 255));
      while (c == SOF_BYTE || c == EOF_BYTE)
        c = 8'($urandom_range(0, 255));
      return c;
    end
    case (pos)
      0:       d = (r < 80) ? $urandom_range(0, 3) : $urandom_range(4, 9);
      1:       d = (r < 80) ? $urandom_range(1, 2) : $urandom_range(0, 9);
      2:       d = (r < 80) ? 0 : $urandom_range(0, 9);
      3:       d = (r < 80) ? $urandom_range(6, 7) : $urandom_range(0, 9);
      default: d = $urandom_range(0, 9);
    endcase
    return CH_ZERO + 8'(d);
  endfunction

  // One random frame. Most are full fourteen-character frames; the rest are short,
  // longer than the fields and up to past the buffer, restarted after a broken
  // opening, or plain noise between frames.
  task automatic queue_random_frame();
    int unsigned kind;
    int unsigned len;
    int unsigned n;
    logic [7:0]  b;
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      // Noise while no frame is open; an opening byte is turned into a stray CR.
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        b = 8'($urandom_range(0, 255));
        if (b == SOF_BYTE)
          b = EOF_BYTE;
        pending_bytes.push_back(b);
      end
      return;
    end
    if (kind < 14) begin
      // A frame that is abandoned and reopened by the next start byte.
      offer(SOF_BYTE);
      n = $urandom_range(0, 12);
      for (int i = 0; i < n; i++)
        offer(pick_char(i));
    end
    if (kind < 70)
      len = FIELD_SPAN;
    else if (kind < 84)
      len = $urandom_range(0, FIELD_SPAN - 1);
    else
      len = $urandom_range(FIELD_SPAN + 1, FRAME_DEPTH + 8);
    offer(SOF_BYTE);
    for (int i = 0; i < len; i++)
      offer(pick_char(i));
    offer(EOF_BYTE);
  endtask

  // Stimulus and end of test. Queue updates happen on the falling edge so they never
  // race the driver, which only looks at the queue on the rising edge.
  initial begin : stimulus
    int unsigned phase_end;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames, no idling. A CR and a byte outside any frame are ignored.
    pending_bytes.push_back(EOF_BYTE);
    pending_bytes.push_back(8'hFF);
    // Full-scale negative temperature, Celsius, percent oxygen.
    offer(SOF_BYTE);
    offer_text("21061299999999");
    offer(EOF_BYTE);
    // A restart inside a frame, then all-zero readings in Fahrenheit and mg/L.
    offer(SOF_BYTE);
    offer_text("9");
    offer(SOF_BYTE);
    offer_text("02 70000000000");
    offer(EOF_BYTE);
    // Invalid polarity holds the temperature; signs and NUL cut digit runs short.
    offer(SOF_BYTE);
    offer_text("81+6 3-12 4");
    offer(8'h00);
    offer(EOF_BYTE);
    // A one-character frame with negative polarity, then an empty frame.
    offer(SOF_BYTE);
    offer_text("3");
    offer(EOF_BYTE);
    offer(SOF_BYTE);
    offer(EOF_BYTE);

    // Phase one: no idling, plus a long receiver hold-off while frames keep coming,
    // so the output register fills and the decoder has to push back on its input.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    @(negedge clk);
    hold_req = 1'b0;
    phase_end = bytes_queued + PHASE_BYTES;
    while (bytes_queued < phase_end)
      queue_random_frame();
    while (pending_bytes.size() != 0)
      @(negedge clk);

    // Sender mostly idle.
    send_idle_pct  = 75;
    recv_stall_pct = 0;
    phase_end = bytes_queued + PHASE_BYTES;
    while (bytes_queued < phase_end)
      queue_random_frame();
    while (pending_bytes.size() != 0)
      @(negedge clk);

    // Receiver mostly stalling.
    send_idle_pct  = 0;
    recv_stall_pct = 75;
    phase_end = bytes_queued + PHASE_BYTES;
    while (bytes_queued < phase_end)
      queue_random_frame();
    while (pending_bytes.size() != 0)
      @(negedge clk);

    // Light idling on both sides.
    send_idle_pct  = 16;
    recv_stall_pct = 16;
    phase_end = bytes_queued + PHASE_BYTES;
    while (bytes_queued < phase_end)
      queue_random_frame();
    while (pending_bytes.size() != 0)
      @(negedge clk);

    // Drain, then give the pipeline time to show any stray reading.
    while (readings_due.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (fail_count == 0 && readings_due.size() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
